// ===== rtl/max_heap_priority_queue_unit_assert.svh =====
// assertion macros used by the heap queue datapath
`ifndef MAX_HEAP_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define MAX_HEAP_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, checked out of reset
`define MHPQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, checked out of reset
`define MHPQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MHPQ_ASSERT_IMP(label, ante, cons, msg)
`define MHPQ_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/mhpq_pkg.sv =====
// types and constants of the heap priority queue
`timescale 1ns / 1ps
package mhpq_pkg;

  // request opcodes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // one heap entry
  typedef struct packed {
    logic [15:0] prio;
    logic [15:0] job;
    logic [15:0] pages;
  } mhpq_entry_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_DEL_LAST,
    S_DEL_LOAD,
    S_DEL_RD,
    S_DEL_CMP,
    S_FIN_RD,
    S_FIN_LOAD
  } mhpq_state_t;

  // read address select of port 0
  typedef enum logic [1:0] {
    RD_ZERO,
    RD_PARENT,
    RD_LAST,
    RD_CHILD
  } mhpq_rd_sel_t;

  // write data select
  typedef enum logic [1:0] {
    WR_CUR,
    WR_PARENT,
    WR_BEST
  } mhpq_wr_sel_t;

  // controller to datapath commands
  typedef struct packed {
    logic         accept;
    logic         pos_from_count;
    logic         pos_zero;
    logic         pos_up;
    logic         pos_down;
    logic         cur_from_rd;
    mhpq_rd_sel_t rd_sel;
    logic         wr_en;
    mhpq_wr_sel_t wr_sel;
    logic         out_load;
  } mhpq_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic op_insert;
    logic op_remove;
    logic is_full;
    logic is_empty;
    logic last_one;
    logic pos_is_root;
    logic parent_lower;
    logic leaf;
    logic child_wins;
    logic out_stall;
  } mhpq_stat_t;

endpackage

// ===== rtl/max_heap_priority_queue_unit.sv =====
// Binary max-heap priority queue of jobs (priority, job number, page count).
// Input channel in_*: one request per valid/ready handshake; in_opcode selects
// insert, remove top or read top (code three acts as a read).
// Result channel out_*: exactly one result per request, giving the status, the
// root entry after the request (zeros when empty) and the entry count.
// Sequence from acceptance to out_valid: a read, a refused request and removal
// of the only entry go straight to reading the root and loading the result; an
// insert first sifts up, and a remove first reads the last entry, loads it as
// the moving entry at the root and sifts down. A sift moves at most
// log2(HEAP_DEPTH) levels.
// Each level of a sift is a memory read step and then a compare/write step on
// the heap memory.
// One request is worked at a time; in_ready returns the cycle after the result
// is loaded into the output register, so the next request overlaps a pending
// result, and no new request is taken while one is still being worked.
// If the receiver stalls, the finished result waits in the output register and
// a following request runs up to its own result, then holds.
// Reset (rst_n low, synchronous) empties the queue and drops any pending
// result; the heap memory needs no clearing pass.
`timescale 1ns / 1ps
module max_heap_priority_queue_unit import mhpq_pkg::*; #(
  parameter int HEAP_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [15:0] in_priority_req,
  input  logic [15:0] in_job_number,
  input  logic [15:0] in_page_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_top_valid,
  output logic [15:0] out_top_priority,
  output logic [15:0] out_top_job_number,
  output logic [15:0] out_top_page_count,
  output logic [6:0]  out_entry_total
);

  mhpq_cmd_t  cmd;
  mhpq_stat_t stat;

  // sequencer
  mhpq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // heap storage and result path
  mhpq_datapath #(
    .HEAP_DEPTH (HEAP_DEPTH)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_opcode          (in_opcode),
    .in_priority_req    (in_priority_req),
    .in_job_number      (in_job_number),
    .in_page_count      (in_page_count),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_top_valid      (out_top_valid),
    .out_top_priority   (out_top_priority),
    .out_top_job_number (out_top_job_number),
    .out_top_page_count (out_top_page_count),
    .out_entry_total    (out_entry_total)
  );

endmodule

// ===== rtl/mhpq_ctrl.sv =====
// sequencing state machine of the heap queue
`timescale 1ns / 1ps
module mhpq_ctrl import mhpq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  mhpq_stat_t stat,
  output mhpq_cmd_t  cmd
);

  mhpq_state_t state_r;
  mhpq_state_t state_nxt;
  logic        accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (stat.op_insert && !stat.is_full) begin
            state_nxt = S_INS_RD;
          end else if (stat.op_remove && !stat.is_empty && !stat.last_one) begin
            state_nxt = S_DEL_LAST;
          end else begin
            state_nxt = S_FIN_RD;
          end
        end
      end
      S_INS_RD: begin
        state_nxt = stat.pos_is_root ? S_FIN_RD : S_INS_CMP;
      end
      S_INS_CMP: begin
        state_nxt = stat.parent_lower ? S_INS_RD : S_FIN_RD;
      end
      S_DEL_LAST: begin
        state_nxt = S_DEL_LOAD;
      end
      S_DEL_LOAD: begin
        state_nxt = S_DEL_RD;
      end
      S_DEL_RD: begin
        state_nxt = stat.leaf ? S_FIN_RD : S_DEL_CMP;
      end
      S_DEL_CMP: begin
        state_nxt = stat.child_wins ? S_DEL_RD : S_FIN_RD;
      end
      S_FIN_RD: begin
        state_nxt = S_FIN_LOAD;
      end
      S_FIN_LOAD: begin
        if (!stat.out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // command outputs
  always_comb begin
    cmd = '0;
    cmd.rd_sel = RD_ZERO;
    cmd.wr_sel = WR_CUR;
    case (state_r)
      S_IDLE: begin
        cmd.accept         = accept;
        cmd.pos_from_count = accept;
      end
      S_INS_RD: begin
        if (stat.pos_is_root) begin
          cmd.wr_en = 1'b1;
        end else begin
          cmd.rd_sel = RD_PARENT;
        end
      end
      S_INS_CMP: begin
        cmd.wr_en = 1'b1;
        if (stat.parent_lower) begin
          cmd.wr_sel = WR_PARENT;
          cmd.pos_up = 1'b1;
        end
      end
      S_DEL_LAST: begin
        cmd.rd_sel = RD_LAST;
      end
      S_DEL_LOAD: begin
        cmd.cur_from_rd = 1'b1;
        cmd.pos_zero    = 1'b1;
      end
      S_DEL_RD: begin
        if (stat.leaf) begin
          cmd.wr_en = 1'b1;
        end else begin
          cmd.rd_sel = RD_CHILD;
        end
      end
      S_DEL_CMP: begin
        cmd.wr_en = 1'b1;
        if (stat.child_wins) begin
          cmd.wr_sel   = WR_BEST;
          cmd.pos_down = 1'b1;
        end
      end
      S_FIN_RD: begin
        cmd.rd_sel = RD_ZERO;
      end
      S_FIN_LOAD: begin
        cmd.out_load = !stat.out_stall;
      end
      default: begin
        cmd.rd_sel = RD_ZERO;
      end
    endcase
  end

endmodule

// ===== rtl/mhpq_datapath.sv =====
// heap memory, count, sift registers and result register
`timescale 1ns / 1ps
`include "max_heap_priority_queue_unit_assert.svh"
module mhpq_datapath import mhpq_pkg::*; #(
  parameter int HEAP_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  mhpq_cmd_t   cmd,
  output mhpq_stat_t  stat,
  input  logic [1:0]  in_opcode,
  input  logic [15:0] in_priority_req,
  input  logic [15:0] in_job_number,
  input  logic [15:0] in_page_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_top_valid,
  output logic [15:0] out_top_priority,
  output logic [15:0] out_top_job_number,
  output logic [15:0] out_top_page_count,
  output logic [6:0]  out_entry_total
);

  localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int IW = AW + 2;

  // heap storage
  mhpq_entry_t mem [0:HEAP_DEPTH-1];
  mhpq_entry_t rd0_r;
  mhpq_entry_t rd1_r;
  logic [AW-1:0] rd_addr0;
  logic [AW-1:0] rd_addr1;
  mhpq_entry_t wr_data;

  // sift and count registers
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic [AW-1:0] pos_r;
  logic [AW-1:0] pos_nxt;
  mhpq_entry_t   cur_r;
  mhpq_entry_t   cur_nxt;
  logic [1:0]    status_r;
  logic [1:0]    status_nxt;

  // result register
  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic        out_top_valid_r;
  mhpq_entry_t out_top_r;
  logic [6:0]  out_total_r;

  logic [AW-1:0]   parent_idx;
  logic [IW-1:0]   left_ext;
  logic [IW-1:0]   right_ext;
  logic [IW-1:0]   count_ext;
  logic            has_right;
  logic            pick_right;
  mhpq_entry_t     best;
  logic [AW-1:0]   best_idx;
  logic [CW+6:0]   total_ext;
  logic [CW-1:0]   pos_ext;

  // index arithmetic
  assign parent_idx = (pos_r - AW'(1)) >> 1;
  assign left_ext   = {1'b0, pos_r, 1'b1};
  assign right_ext  = left_ext + IW'(1);
  assign count_ext  = IW'(count_r);
  assign has_right  = right_ext < count_ext;
  assign pick_right = has_right && (rd1_r.prio > rd0_r.prio);
  assign best       = pick_right ? rd1_r : rd0_r;
  assign best_idx   = pick_right ? right_ext[AW-1:0] : left_ext[AW-1:0];

  // status to controller
  always_comb begin
    stat.op_insert    = (in_opcode == OP_INSERT);
    stat.op_remove    = (in_opcode == OP_REMOVE);
    stat.is_full      = (count_r == CW'(HEAP_DEPTH));
    stat.is_empty     = (count_r == '0);
    stat.last_one     = (count_r == CW'(1));
    stat.pos_is_root  = (pos_r == '0);
    stat.parent_lower = (rd0_r.prio < cur_r.prio);
    stat.leaf         = (left_ext >= count_ext);
    stat.child_wins   = (best.prio > cur_r.prio);
    stat.out_stall    = out_valid_r && !out_ready;
  end

  // memory addresses and write data
  always_comb begin
    case (cmd.rd_sel)
      RD_ZERO:   rd_addr0 = '0;
      RD_PARENT: rd_addr0 = parent_idx;
      RD_LAST:   rd_addr0 = count_r[AW-1:0];
      RD_CHILD:  rd_addr0 = left_ext[AW-1:0];
      default:   rd_addr0 = '0;
    endcase
    rd_addr1 = right_ext[AW-1:0];
    case (cmd.wr_sel)
      WR_CUR:    wr_data = cur_r;
      WR_PARENT: wr_data = rd0_r;
      WR_BEST:   wr_data = best;
      default:   wr_data = cur_r;
    endcase
  end

  // heap memory, one write and two registered reads
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[pos_r] <= wr_data;
    end
    rd0_r <= mem[rd_addr0];
    rd1_r <= mem[rd_addr1];
  end

  // next values of count, position, moving entry and status
  always_comb begin
    count_nxt  = count_r;
    pos_nxt    = pos_r;
    cur_nxt    = cur_r;
    status_nxt = status_r;
    if (cmd.accept) begin
      cur_nxt = '{prio: in_priority_req, job: in_job_number, pages: in_page_count};
      status_nxt = ST_OK;
      if (stat.op_insert) begin
        if (stat.is_full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CW'(1);
        end
      end else if (stat.op_remove) begin
        if (stat.is_empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          count_nxt = count_r - CW'(1);
        end
      end
    end
    if (cmd.cur_from_rd) begin
      cur_nxt = rd0_r;
    end
    if (cmd.pos_from_count) begin
      pos_nxt = count_r[AW-1:0];
    end else if (cmd.pos_zero) begin
      pos_nxt = '0;
    end else if (cmd.pos_up) begin
      pos_nxt = parent_idx;
    end else if (cmd.pos_down) begin
      pos_nxt = best_idx;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    cur_r    <= cur_nxt;
    status_r <= status_nxt;
  end

  // entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign total_ext = {7'b0, count_r};

  // result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result fields
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r    <= status_r;
      out_top_valid_r <= !stat.is_empty;
      out_top_r       <= stat.is_empty ? '0 : rd0_r;
      out_total_r     <= total_ext[6:0];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_top_valid      = out_top_valid_r;
  assign out_top_priority   = out_top_r.prio;
  assign out_top_job_number = out_top_r.job;
  assign out_top_page_count = out_top_r.pages;
  assign out_entry_total    = out_total_r;

  assign pos_ext = CW'(pos_r);

  // checks
  `MHPQ_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CW'(HEAP_DEPTH), "entry count past depth")
  `MHPQ_ASSERT_IMP(a_write_in_range, cmd.wr_en, pos_ext < count_r, "write outside live entries")
  `MHPQ_ASSERT_IMP(a_load_free, cmd.out_load, !(out_valid_r && !out_ready), "result overwritten")
  `MHPQ_ASSERT_NXT(a_full_status, cmd.accept && stat.op_insert && stat.is_full, status_r == ST_FULL, "full insert not flagged")

endmodule
